// File: design/plbl_pkg.sv
// Package with the shared types, constants and helpers of the path minimum lifting unit.
`timescale 1ns / 1ps

package plbl_pkg;

  localparam int MAX_NODES = 1024;
  localparam int LEVELS    = 10;

  // Field widths of the transactions.
  localparam int IDX_W    = 10;
  localparam int WEIGHT_W = 32;

  // Internal widths derived from the table size.
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int ROW_DEPTH = MAX_NODES * LEVELS;
  localparam int ROW_AW    = $clog2(ROW_DEPTH);
  localparam int ROW_W     = NODE_W + WEIGHT_W;
  localparam int KW        = $clog2(LEVELS + 1);
  localparam int LW        = ((LEVELS > NODE_W) ? LEVELS : NODE_W) + 1;

  localparam logic KIND_QUERY = 1'b1;

  localparam logic [WEIGHT_W-1:0] ALL_ONES = '1;

  typedef struct packed {
    logic                kind;
    logic [IDX_W-1:0]    parent_node;
    logic [WEIGHT_W-1:0] edge_weight;
    logic [IDX_W-1:0]    end_a;
    logic [IDX_W-1:0]    end_b;
  } in_item_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] min_weight;
    logic [IDX_W-1:0]    meeting_node;
    logic                status;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AP_START,
    ST_AP_DEPW,
    ST_AP_RD,
    ST_AP_WB,
    ST_AP_DONE,
    ST_Q_START,
    ST_Q_DEP,
    ST_L_RD,
    ST_L_WB,
    ST_Q_EQ,
    ST_C_RD,
    ST_C_WB,
    ST_F_RD,
    ST_F_WB,
    ST_Q_OUT
  } state_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic start;
    logic kind;
    logic app_bad;
    logic q_bad;
    logic k_zero;
    logic k_last;
    logic k_full;
    logic ab_eq;
  } stat_t;

  // Step strobes from the sequencer to the datapath.
  typedef struct packed {
    logic busy;
    logic out_valid;
    logic ld_in;
    logic ap_start;
    logic ap_depw;
    logic ap_rd;
    logic ap_wb;
    logic ap_done;
    logic q_start;
    logic q_dep;
    logic l_rd;
    logic l_wb;
    logic q_eq;
    logic c_rd;
    logic c_wb;
    logic f_rd;
    logic f_wb;
  } ctrl_t;

  // Address of one entry of the lifting table: row of the node, column of the level.
  function automatic logic [ROW_AW-1:0] row_addr(input logic [NODE_W-1:0] node,
                                                 input logic [KW-1:0] lvl);
    logic [ROW_AW-1:0] base;
    base = ROW_AW'(node) * ROW_AW'(LEVELS);
    return base + ROW_AW'(lvl);
  endfunction

endpackage

// File: design/plbl_ram.sv
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps

module plbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: design/plbl_ctrl.sv
// Sequencer that steps the shared table walk through appends and queries.
`timescale 1ns / 1ps

module plbl_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  plbl_pkg::stat_t stat,
  output plbl_pkg::ctrl_t ctrl
);

  plbl_pkg::state_t state_r;
  plbl_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= plbl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      plbl_pkg::ST_IDLE: begin
        if (stat.start) begin
          if (stat.kind == plbl_pkg::KIND_QUERY) begin
            state_nxt = plbl_pkg::ST_Q_START;
          end else if (!stat.app_bad) begin
            state_nxt = plbl_pkg::ST_AP_START;
          end
        end
      end
      plbl_pkg::ST_AP_START: state_nxt = plbl_pkg::ST_AP_DEPW;
      plbl_pkg::ST_AP_DEPW: begin
        state_nxt = stat.k_full ? plbl_pkg::ST_AP_DONE : plbl_pkg::ST_AP_RD;
      end
      plbl_pkg::ST_AP_RD:   state_nxt = plbl_pkg::ST_AP_WB;
      plbl_pkg::ST_AP_WB: begin
        state_nxt = stat.k_last ? plbl_pkg::ST_AP_DONE : plbl_pkg::ST_AP_RD;
      end
      plbl_pkg::ST_AP_DONE: state_nxt = plbl_pkg::ST_IDLE;
      plbl_pkg::ST_Q_START: begin
        state_nxt = stat.q_bad ? plbl_pkg::ST_Q_OUT : plbl_pkg::ST_Q_DEP;
      end
      plbl_pkg::ST_Q_DEP:   state_nxt = plbl_pkg::ST_L_RD;
      plbl_pkg::ST_L_RD:    state_nxt = plbl_pkg::ST_L_WB;
      plbl_pkg::ST_L_WB: begin
        state_nxt = stat.k_zero ? plbl_pkg::ST_Q_EQ : plbl_pkg::ST_L_RD;
      end
      plbl_pkg::ST_Q_EQ: begin
        state_nxt = stat.ab_eq ? plbl_pkg::ST_Q_OUT : plbl_pkg::ST_C_RD;
      end
      plbl_pkg::ST_C_RD:    state_nxt = plbl_pkg::ST_C_WB;
      plbl_pkg::ST_C_WB: begin
        state_nxt = stat.k_zero ? plbl_pkg::ST_F_RD : plbl_pkg::ST_C_RD;
      end
      plbl_pkg::ST_F_RD:    state_nxt = plbl_pkg::ST_F_WB;
      plbl_pkg::ST_F_WB:    state_nxt = plbl_pkg::ST_Q_OUT;
      plbl_pkg::ST_Q_OUT:   state_nxt = plbl_pkg::ST_IDLE;
      default:              state_nxt = plbl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl      = '0;
    ctrl.busy = (state_r != plbl_pkg::ST_IDLE);
    unique case (state_r)
      plbl_pkg::ST_IDLE:     ctrl.ld_in     = stat.start;
      plbl_pkg::ST_AP_START: ctrl.ap_start  = 1'b1;
      plbl_pkg::ST_AP_DEPW:  ctrl.ap_depw   = 1'b1;
      plbl_pkg::ST_AP_RD:    ctrl.ap_rd     = 1'b1;
      plbl_pkg::ST_AP_WB:    ctrl.ap_wb     = 1'b1;
      plbl_pkg::ST_AP_DONE:  ctrl.ap_done   = 1'b1;
      plbl_pkg::ST_Q_START:  ctrl.q_start   = 1'b1;
      plbl_pkg::ST_Q_DEP:    ctrl.q_dep     = 1'b1;
      plbl_pkg::ST_L_RD:     ctrl.l_rd      = 1'b1;
      plbl_pkg::ST_L_WB:     ctrl.l_wb      = 1'b1;
      plbl_pkg::ST_Q_EQ:     ctrl.q_eq      = 1'b1;
      plbl_pkg::ST_C_RD:     ctrl.c_rd      = 1'b1;
      plbl_pkg::ST_C_WB:     ctrl.c_wb      = 1'b1;
      plbl_pkg::ST_F_RD:     ctrl.f_rd      = 1'b1;
      plbl_pkg::ST_F_WB:     ctrl.f_wb      = 1'b1;
      plbl_pkg::ST_Q_OUT:    ctrl.out_valid = 1'b1;
      default:               ctrl.busy      = 1'b1;
    endcase
  end

endmodule

// File: design/path_min_binary_lifting_unit.sv
// Top level of the path minimum unit: binary lifting table, datapath and sequencer.
`timescale 1ns / 1ps
// Each query level is a table read and update pair; an unloaded endpoint goes straight to
// the result, and the common climb runs only when neither endpoint is an ancestor of the
// other. One transaction at a time: the next is accepted while busy is low. An append is
// busy with no result; a rejected append is never busy. The receiver cannot stall.
// Reset is synchronous, active low: sequencer idle, node count one; the tables are not
// cleared, the root row is logic.

module path_min_binary_lifting_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  plbl_pkg::in_item_t  in_data,
  output logic                out_valid,
  output plbl_pkg::out_item_t out_data
);

  localparam int NW = plbl_pkg::NODE_W;
  localparam int WW = plbl_pkg::WEIGHT_W;

  plbl_pkg::ctrl_t ctrl;
  plbl_pkg::stat_t stat;

  // Control state.
  logic [plbl_pkg::CNT_W-1:0] node_count_r, node_count_nxt;

  // Working registers. In an append, a_r carries the current ancestor and best_r the
  // running segment minimum; in a query they hold endpoint a and the path minimum.
  logic [NW-1:0]           a_r, a_nxt;
  logic [NW-1:0]           b_r, b_nxt;
  logic [NW-1:0]           diff_r, diff_nxt;
  logic [NW-1:0]           meet_r, meet_nxt;
  logic [WW-1:0]           best_r, best_nxt;
  logic                    status_r, status_nxt;
  logic [plbl_pkg::KW-1:0] k_r, k_nxt;

  // Flags that mark a read of the root, whose row and depth are implicit.
  logic za_r, zb_r, dza_r, dzb_r;

  // Lifting table ports.
  logic                        row_we;
  logic [plbl_pkg::ROW_AW-1:0] row_waddr, row_raddr_a, row_raddr_b;
  logic [plbl_pkg::ROW_W-1:0]  row_wdata, row_rdata_a, row_rdata_b;
  logic [NW-1:0]               node_sel_a;
  logic [plbl_pkg::KW-1:0]     lvl_sel_a, lvl_sel_b;

  // Depth table ports.
  logic          dep_we;
  logic [NW-1:0] dep_rdata_a, dep_rdata_b;

  // Row entries with the root override applied.
  logic [NW-1:0] anc_a, anc_b, dep_a, dep_b;
  logic [WW-1:0] seg_a, seg_b;

  // Shared minimum unit and lift step decision.
  logic [WW-1:0]     min1, min2;
  logic [plbl_pkg::LW-1:0] diff_ext, step_pow;
  logic              take;

  logic [NW-1:0] new_node;
  logic          q_bad_in, app_bad_in;

  assign new_node = NW'(node_count_r);

  assign q_bad_in   = (plbl_pkg::CNT_W'(in_data.end_a) >= node_count_r) ||
                      (plbl_pkg::CNT_W'(in_data.end_b) >= node_count_r);
  assign app_bad_in = (plbl_pkg::CNT_W'(in_data.parent_node) >= node_count_r) ||
                      (node_count_r == plbl_pkg::CNT_W'(plbl_pkg::MAX_NODES));

  assign stat.start   = start;
  assign stat.kind    = in_data.kind;
  assign stat.app_bad = app_bad_in;
  assign stat.q_bad   = status_r;
  assign stat.k_zero  = (k_r == '0);
  assign stat.k_last  = (k_r == plbl_pkg::KW'(plbl_pkg::LEVELS - 1));
  assign stat.k_full  = (k_r == plbl_pkg::KW'(plbl_pkg::LEVELS));
  assign stat.ab_eq   = (a_r == b_r);

  plbl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // Root rows read as ancestor zero and segment minimum all ones; root depth is zero.
  assign anc_a = za_r  ? '0 : row_rdata_a[plbl_pkg::ROW_W-1:WW];
  assign seg_a = za_r  ? plbl_pkg::ALL_ONES : row_rdata_a[WW-1:0];
  assign anc_b = zb_r  ? '0 : row_rdata_b[plbl_pkg::ROW_W-1:WW];
  assign seg_b = zb_r  ? plbl_pkg::ALL_ONES : row_rdata_b[WW-1:0];
  assign dep_a = dza_r ? '0 : dep_rdata_a;
  assign dep_b = dzb_r ? '0 : dep_rdata_b;

  assign min1 = (seg_a < best_r) ? seg_a : best_r;
  assign min2 = (seg_b < min1) ? seg_b : min1;

  // The deeper endpoint climbs 2^k levels whenever the remaining depth gap allows it.
  assign diff_ext = plbl_pkg::LW'(diff_r);
  assign step_pow = plbl_pkg::LW'(1) << k_r;
  assign take     = (diff_ext >= step_pow);

  // Read address selection for the two table ports.
  always_comb begin
    if (ctrl.ap_rd) begin
      node_sel_a = a_r;
      lvl_sel_a  = plbl_pkg::KW'(k_r - 1'b1);
    end else if (ctrl.l_rd) begin
      node_sel_a = b_r;
      lvl_sel_a  = k_r;
    end else if (ctrl.f_rd) begin
      node_sel_a = a_r;
      lvl_sel_a  = '0;
    end else begin
      node_sel_a = a_r;
      lvl_sel_a  = k_r;
    end
    lvl_sel_b = ctrl.f_rd ? '0 : k_r;
  end

  assign row_raddr_a = plbl_pkg::row_addr(node_sel_a, lvl_sel_a);
  assign row_raddr_b = plbl_pkg::row_addr(b_r, lvl_sel_b);

  // An append writes level zero from the item, then each higher level from the
  // ancestor row read in the cycle before.
  assign row_we    = ctrl.ap_start || ctrl.ap_wb;
  assign row_waddr = plbl_pkg::row_addr(new_node, ctrl.ap_start ? '0 : k_r);
  assign row_wdata = ctrl.ap_start ? {a_r, best_r} : {anc_a, min1};

  assign dep_we = ctrl.ap_depw;

  plbl_ram #(
    .WIDTH (plbl_pkg::ROW_W),
    .DEPTH (plbl_pkg::ROW_DEPTH)
  ) u_row_ram (
    .clk     (clk),
    .we      (row_we),
    .waddr   (row_waddr),
    .wdata   (row_wdata),
    .raddr_a (row_raddr_a),
    .raddr_b (row_raddr_b),
    .rdata_a (row_rdata_a),
    .rdata_b (row_rdata_b)
  );

  plbl_ram #(
    .WIDTH (NW),
    .DEPTH (plbl_pkg::MAX_NODES)
  ) u_depth_ram (
    .clk     (clk),
    .we      (dep_we),
    .waddr   (new_node),
    .wdata   (NW'(dep_a + 1'b1)),
    .raddr_a (a_r),
    .raddr_b (b_r),
    .rdata_a (dep_rdata_a),
    .rdata_b (dep_rdata_b)
  );

  // Next values of the working registers.
  always_comb begin
    node_count_nxt = node_count_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    diff_nxt       = diff_r;
    meet_nxt       = meet_r;
    best_nxt       = best_r;
    status_nxt     = status_r;
    k_nxt          = k_r;

    if (ctrl.ld_in) begin
      // Accepting a transaction loads either the append or the query operands.
      if (in_data.kind == plbl_pkg::KIND_QUERY) begin
        a_nxt    = NW'(in_data.end_a);
        best_nxt = plbl_pkg::ALL_ONES;
      end else begin
        a_nxt    = NW'(in_data.parent_node);
        best_nxt = in_data.edge_weight;
      end
      b_nxt      = NW'(in_data.end_b);
      status_nxt = q_bad_in;
      meet_nxt   = '0;
    end

    if (ctrl.ap_start) begin
      k_nxt = plbl_pkg::KW'(1);
    end

    if (ctrl.ap_wb) begin
      a_nxt    = anc_a;
      best_nxt = min1;
      k_nxt    = plbl_pkg::KW'(k_r + 1'b1);
    end

    if (ctrl.ap_done) begin
      node_count_nxt = plbl_pkg::CNT_W'(node_count_r + 1'b1);
    end

    if (ctrl.q_dep) begin
      // Keep the shallower endpoint in a and the deeper one in b.
      if (dep_a > dep_b) begin
        a_nxt    = b_r;
        b_nxt    = a_r;
        diff_nxt = NW'(dep_a - dep_b);
      end else begin
        diff_nxt = NW'(dep_b - dep_a);
      end
      k_nxt = plbl_pkg::KW'(plbl_pkg::LEVELS - 1);
    end

    if (ctrl.l_wb) begin
      if (take) begin
        best_nxt = min1;
        b_nxt    = anc_a;
        diff_nxt = NW'(diff_ext - step_pow);
      end
      k_nxt = plbl_pkg::KW'(k_r - 1'b1);
    end

    if (ctrl.q_eq) begin
      meet_nxt = a_r;
      k_nxt    = plbl_pkg::KW'(plbl_pkg::LEVELS - 1);
    end

    if (ctrl.c_wb) begin
      // Both endpoints climb together only while their ancestors still differ.
      if (anc_a != anc_b) begin
        best_nxt = min2;
        a_nxt    = anc_a;
        b_nxt    = anc_b;
      end
      k_nxt = plbl_pkg::KW'(k_r - 1'b1);
    end

    if (ctrl.f_wb) begin
      // The level-zero entries of both endpoints, their links into the common ancestor, close the path.
      best_nxt = min2;
      meet_nxt = anc_a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= plbl_pkg::CNT_W'(1);
    end else begin
      node_count_r <= node_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    diff_r   <= diff_nxt;
    meet_r   <= meet_nxt;
    best_r   <= best_nxt;
    status_r <= status_nxt;
    k_r      <= k_nxt;
    za_r     <= (node_sel_a == '0);
    zb_r     <= (b_r == '0);
    dza_r    <= (a_r == '0);
    dzb_r    <= (b_r == '0);
  end

  assign busy      = ctrl.busy;
  assign out_valid = ctrl.out_valid;

  assign out_data.min_weight   = best_r;
  assign out_data.meeting_node = plbl_pkg::IDX_W'(meet_r);
  assign out_data.status       = status_r;

  // A result is a single-cycle strobe.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // An accepted query always makes the unit busy.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.kind == plbl_pkg::KIND_QUERY)) |=> busy)
    else $error("query accepted without starting the sequencer");

  // An append to a full table leaves the node count as it was.
  a_full_append: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.kind != plbl_pkg::KIND_QUERY) &&
     (node_count_r == plbl_pkg::CNT_W'(plbl_pkg::MAX_NODES)))
    |=> (node_count_r == $past(node_count_r)))
    else $error("append to a full table changed the node count");

  // An unloaded endpoint reports an empty path at the root.
  a_bad_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status) |->
    ((out_data.min_weight == plbl_pkg::ALL_ONES) && (out_data.meeting_node == '0)))
    else $error("unloaded endpoint result carries path data");

endmodule
